// ===== hdl/dense_graph_shortest_paths_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the dense graph shortest paths block
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef DENSE_GRAPH_SHORTEST_PATHS_ASSERT_SVH
`define DENSE_GRAPH_SHORTEST_PATHS_ASSERT_SVH

// same-cycle implication
`define DGSP_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dgsp assertion failed");

// next-cycle implication
`define DGSP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dgsp assertion failed");

`endif

// ===== hdl/dgsp_pkg.sv =====
// ----------------------------------------------------------------------------
// dgsp_pkg
// Types and constants shared by the dense graph shortest paths block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dgsp_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int WEIGHT_BITS  = 16;

    localparam int VFIELD_W = 6;
    localparam int WFIELD_W = 16;
    localparam int DIST_W   = 22;
    localparam int CFG_W    = 7;
    localparam int CMP_W    = VFIELD_W + 1;

    localparam int VIDX_W   = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int VCNT_W   = $clog2(MAX_VERTICES + 1);
    localparam int ADJ_AW   = 2 * VIDX_W;

    localparam logic [CFG_W-1:0] VERTEX_COUNT_RESET = CFG_W'(64);

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_RUN  = 1'b1;

    typedef struct packed {
        logic                op;
        logic [VFIELD_W-1:0] row;
        logic [VFIELD_W-1:0] col;
        logic [WFIELD_W-1:0] weight;
        logic [VFIELD_W-1:0] source;
    } in_t;

    typedef struct packed {
        logic [VFIELD_W-1:0] vertex;
        logic [DIST_W-1:0]   distance;
        logic                unreachable;
        logic                last;
    } out_t;

endpackage

// ===== hdl/dgsp_ram.sv =====
// ----------------------------------------------------------------------------
// dgsp_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dgsp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/dense_graph_shortest_paths.sv =====
// ----------------------------------------------------------------------------
// dense_graph_shortest_paths
// Single-source shortest paths over a dense weighted adjacency matrix.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: an item is taken when start is high and busy is low.
//   op = load writes weight into matrix entry (row, col) in the same cycle;
//   loads outside the active vertex count are dropped. Loads never raise
//   busy. A weight of zero marks a missing edge. op = run starts a search
//   from source; busy stays high until the last result is shown. Each
//   settle step of a run is one selection scan and, if the picked vertex
//   is reached, one relaxation scan over the distance memory and matrix
//   memory read ports, one vertex per cycle.
//   Results: one beat per vertex in index order, each on result for exactly
//   one cycle with result_valid high; the final beat carries last. The
//   receiver cannot stall, so beats are never held back.
//   Config: cfg_data sets vertex_count when cfg_valid and cfg_ready are high;
//   write it only while idle. Reset returns vertex_count to 64 and the
//   sequencer to idle; matrix contents are undefined until loaded.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dense_graph_shortest_paths (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  dgsp_pkg::in_t                item,
    output logic                         result_valid,
    output dgsp_pkg::out_t               result,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [dgsp_pkg::CFG_W-1:0]   cfg_data
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PICK  = 3'd1;
    localparam logic [2:0] S_SEL   = 3'd2;
    localparam logic [2:0] S_RELAX = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    localparam int VIDX_W = dgsp_pkg::VIDX_W;
    localparam int VCNT_W = dgsp_pkg::VCNT_W;
    localparam int DIST_W = dgsp_pkg::DIST_W;
    localparam int CMP_W  = dgsp_pkg::CMP_W;
    localparam int NV     = dgsp_pkg::MAX_VERTICES;

    logic [dgsp_pkg::CFG_W-1:0] vcount_reg;

    logic [2:0]        state_reg, state_next;
    logic [VCNT_W-1:0] cnt_reg, cnt_next;
    logic [VCNT_W-1:0] rem_reg, rem_next;
    logic              pv_reg, pv_next;
    logic [VIDX_W-1:0] pidx_reg;
    logic              have_reg, have_next;
    logic              pick_reached_reg, pick_reached_next;
    logic [VIDX_W-1:0] pick_reg, pick_next;
    logic [DIST_W-1:0] pick_dist_reg, pick_dist_next;
    logic [NV-1:0]     reached_reg, reached_next;
    logic [NV-1:0]     visited_reg, visited_next;
    logic              out_valid_reg, out_valid_next;
    dgsp_pkg::out_t    out_reg, out_next;

    logic [VCNT_W-1:0] n_eff;
    logic              accept;
    logic              issue;
    logic              last_idx;
    logic              take;
    logic [DIST_W-1:0] cand;

    logic                               adj_we;
    logic [dgsp_pkg::ADJ_AW-1:0]        adj_waddr;
    logic [dgsp_pkg::WEIGHT_BITS-1:0]   adj_wdata;
    logic [dgsp_pkg::ADJ_AW-1:0]        adj_raddr;
    logic [dgsp_pkg::WEIGHT_BITS-1:0]   adj_rdata;

    logic              dist_we;
    logic [VIDX_W-1:0] dist_waddr;
    logic [DIST_W-1:0] dist_wdata;
    logic [DIST_W-1:0] dist_rdata;

    dgsp_ram #(
        .WIDTH (dgsp_pkg::WEIGHT_BITS),
        .DEPTH (2 ** dgsp_pkg::ADJ_AW)
    ) u_adj_ram (
        .clk   (clk),
        .we    (adj_we),
        .waddr (adj_waddr),
        .wdata (adj_wdata),
        .raddr (adj_raddr),
        .rdata (adj_rdata)
    );

    dgsp_ram #(
        .WIDTH (DIST_W),
        .DEPTH (2 ** VIDX_W)
    ) u_dist_ram (
        .clk   (clk),
        .we    (dist_we),
        .waddr (dist_waddr),
        .wdata (dist_wdata),
        .raddr (cnt_reg[VIDX_W-1:0]),
        .rdata (dist_rdata)
    );

    always_comb
    begin
        if (vcount_reg == '0)
        begin
            n_eff = VCNT_W'(1);
        end
        else if (vcount_reg > dgsp_pkg::CFG_W'(NV))
        begin
            n_eff = VCNT_W'(NV);
        end
        else
        begin
            n_eff = VCNT_W'(vcount_reg);
        end
    end

    assign busy         = (state_reg != S_IDLE);
    assign cfg_ready    = !busy;
    assign accept       = start && !busy;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    assign adj_we    = accept && (item.op == dgsp_pkg::OP_LOAD)
                       && (CMP_W'(item.row) < CMP_W'(n_eff))
                       && (CMP_W'(item.col) < CMP_W'(n_eff));
    assign adj_waddr = {item.row[VIDX_W-1:0], item.col[VIDX_W-1:0]};
    assign adj_wdata = item.weight[dgsp_pkg::WEIGHT_BITS-1:0];
    assign adj_raddr = {pick_reg, cnt_reg[VIDX_W-1:0]};

    assign issue    = ((state_reg == S_PICK) || (state_reg == S_RELAX)
                       || (state_reg == S_OUT)) && (cnt_reg < n_eff);
    assign last_idx = pv_reg && (VCNT_W'(pidx_reg) == (n_eff - VCNT_W'(1)));
    assign cand     = pick_dist_reg + DIST_W'(adj_rdata);

    always_comb
    begin
        take = 1'b0;
        if (pv_reg && !visited_reg[pidx_reg])
        begin
            if (reached_reg[pidx_reg])
            begin
                take = !have_reg || !pick_reached_reg || (dist_rdata <= pick_dist_reg);
            end
            else
            begin
                take = !have_reg || !pick_reached_reg;
            end
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        cnt_next          = issue ? cnt_reg + VCNT_W'(1) : cnt_reg;
        rem_next          = rem_reg;
        pv_next           = issue;
        have_next         = have_reg;
        pick_reached_next = pick_reached_reg;
        pick_next         = pick_reg;
        pick_dist_next    = pick_dist_reg;
        reached_next      = reached_reg;
        visited_next      = visited_reg;
        out_valid_next    = 1'b0;
        out_next          = out_reg;
        dist_we           = 1'b0;
        dist_waddr        = pidx_reg;
        dist_wdata        = cand;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && (item.op == dgsp_pkg::OP_RUN))
                begin
                    reached_next = '0;
                    visited_next = '0;
                    if (CMP_W'(item.source) < CMP_W'(n_eff))
                    begin
                        reached_next[item.source[VIDX_W-1:0]] = 1'b1;
                        dist_we    = 1'b1;
                        dist_waddr = item.source[VIDX_W-1:0];
                        dist_wdata = '0;
                    end
                    cnt_next  = '0;
                    have_next = 1'b0;
                    rem_next  = n_eff - VCNT_W'(1);
                    state_next = (n_eff == VCNT_W'(1)) ? S_OUT : S_PICK;
                end
            end
            S_PICK:
            begin
                if (take)
                begin
                    have_next         = 1'b1;
                    pick_next         = pidx_reg;
                    pick_reached_next = reached_reg[pidx_reg];
                    if (reached_reg[pidx_reg])
                    begin
                        pick_dist_next = dist_rdata;
                    end
                end
                if (last_idx)
                begin
                    state_next = S_SEL;
                end
            end
            S_SEL:
            begin
                visited_next[pick_reg] = 1'b1;
                rem_next  = rem_reg - VCNT_W'(1);
                cnt_next  = '0;
                have_next = 1'b0;
                if (pick_reached_reg)
                begin
                    state_next = S_RELAX;
                end
                else
                begin
                    state_next = (rem_reg == VCNT_W'(1)) ? S_OUT : S_PICK;
                end
            end
            S_RELAX:
            begin
                if (pv_reg && !visited_reg[pidx_reg] && (adj_rdata != '0))
                begin
                    if (!reached_reg[pidx_reg] || (cand < dist_rdata))
                    begin
                        dist_we = 1'b1;
                        reached_next[pidx_reg] = 1'b1;
                    end
                end
                if (last_idx)
                begin
                    cnt_next   = '0;
                    have_next  = 1'b0;
                    state_next = (rem_reg == '0) ? S_OUT : S_PICK;
                end
            end
            S_OUT:
            begin
                if (pv_reg)
                begin
                    out_valid_next       = 1'b1;
                    out_next.vertex      = dgsp_pkg::VFIELD_W'(pidx_reg);
                    out_next.distance    = reached_reg[pidx_reg] ? dist_rdata : '0;
                    out_next.unreachable = !reached_reg[pidx_reg];
                    out_next.last        = last_idx;
                end
                if (last_idx)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg       <= dgsp_pkg::VERTEX_COUNT_RESET;
            state_reg        <= S_IDLE;
            cnt_reg          <= '0;
            rem_reg          <= '0;
            pv_reg           <= 1'b0;
            have_reg         <= 1'b0;
            pick_reached_reg <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                vcount_reg <= cfg_data;
            end
            state_reg        <= state_next;
            cnt_reg          <= cnt_next;
            rem_reg          <= rem_next;
            pv_reg           <= pv_next;
            have_reg         <= have_next;
            pick_reached_reg <= pick_reached_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pidx_reg      <= cnt_reg[VIDX_W-1:0];
        pick_reg      <= pick_next;
        pick_dist_reg <= pick_dist_next;
        reached_reg   <= reached_next;
        visited_reg   <= visited_next;
        out_reg       <= out_next;
    end

endmodule

// ===== hdl/dgsp_checker.sv =====
// ----------------------------------------------------------------------------
// dgsp_checker
// Port-level checks on command, busy and result behavior over time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "dense_graph_shortest_paths_assert.svh"

module dgsp_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           start,
    input logic           busy,
    input dgsp_pkg::in_t  item,
    input logic           result_valid,
    input dgsp_pkg::out_t result
);

    logic run_take;
    logic load_take;

    assign run_take  = start && !busy && (item.op == dgsp_pkg::OP_RUN);
    assign load_take = start && !busy && (item.op == dgsp_pkg::OP_LOAD);

    `DGSP_ASSERT_SAME(a_mid_beat_busy, result_valid && !result.last, busy)
    `DGSP_ASSERT_NEXT(a_run_sets_busy, run_take, busy)
    `DGSP_ASSERT_NEXT(a_load_quiet, load_take, !busy && !result_valid)
    `DGSP_ASSERT_NEXT(a_last_ends, result_valid && result.last, !result_valid)
    `DGSP_ASSERT_SAME(a_done_with_last, $fell(busy), result_valid && result.last)

endmodule

bind dense_graph_shortest_paths dgsp_checker u_dgsp_checker (.*);
